[rtl/ctd_pkg.sv]
// ctd_pkg: constants, register indexes and shared types of the camera transfer deframer.
// No dependencies; the front, queue, back, top and bench import it.
`default_nettype none
package ctd_pkg;

  localparam int PACKET_BYTES = 24576;
  localparam int HEADER_BYTES = 32;
  localparam int COUNT_WIDTH  = 24;
  localparam int OFFSET_WIDTH = 15;

  localparam int WIDTH_BITS  = 13;
  localparam int HEIGHT_BITS = 12;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_INDEX_W = 2;
  localparam int PROD_W      = WIDTH_BITS + HEIGHT_BITS + 1;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  localparam int EXP_HI_POS = 6;
  localparam int EXP_LO_POS = 7;
  localparam int SEQ_POS    = 89;

  localparam logic [WIDTH_BITS-1:0]  RST_IMG_WIDTH      = 13'd1280;
  localparam logic [HEIGHT_BITS-1:0] RST_IMG_HEIGHT     = 12'd480;
  localparam logic [COUNT_WIDTH-1:0] RST_TRANSFER_BYTES = 24'd616538;

  localparam logic [CFG_INDEX_W-1:0] REG_IMG_WIDTH      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMG_HEIGHT     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TRANSFER_BYTES = 2'd2;

  localparam logic KIND_PIXEL   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_CW    = QUEUE_AW + 1;

  typedef struct packed {
    logic        has_pix;
    logic [7:0]  pixel;
    logic        has_sum;
    logic [15:0] exposure;
    logic [7:0]  seq;
    logic [7:0]  prev_seq;
    logic        dark;
    logic        ok;
  } entry_t;

  typedef struct packed {
    logic                full;
    logic [QUEUE_CW-1:0] count;
  } q_stat_t;

endpackage
`default_nettype wire

[rtl/ctd_in_if.sv]
// ctd_in_if: input channel of the deframer, one transfer byte per word.
// Depends on nothing.
`default_nettype none
interface ctd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_transfer;
  logic       transfer_error;

  modport source(output valid, data_byte, end_of_transfer, transfer_error, input ready);
  modport sink(input valid, data_byte, end_of_transfer, transfer_error, output ready);
endinterface
`default_nettype wire

[rtl/ctd_out_if.sv]
// ctd_out_if: result channel of the deframer, pixel or frame summary per word.
// Depends on nothing.
`default_nettype none
interface ctd_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  pixel;
  logic [15:0] exposure;
  logic [7:0]  sequence_res;
  logic [7:0]  previous_sequence;
  logic        dark_frame;
  logic        frame_ok;
  logic        last;

  modport source(output valid, kind, pixel, exposure, sequence_res, previous_sequence,
                 dark_frame, frame_ok, last, input ready);
  modport sink(input valid, kind, pixel, exposure, sequence_res, previous_sequence,
               dark_frame, frame_ok, last, output ready);
endinterface
`default_nettype wire

[rtl/ctd_front.sv]
// ctd_front: config registers, packet/frame counters and byte classification.
// Depends on ctd_pkg and ctd_in_if; pushes entries into ctd_queue.
`default_nettype none
module ctd_front
  import ctd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  ctd_in_if.sink                      rx,
  input  wire q_stat_t                qstat,
  output logic                        push,
  output entry_t                      push_data
);

  logic [WIDTH_BITS-1:0]   img_width;
  logic [HEIGHT_BITS-1:0]  img_height;
  logic [COUNT_WIDTH-1:0]  transfer_bytes;
  logic [COUNT_WIDTH-1:0]  flen;
  logic                    settle;

  logic [OFFSET_WIDTH-1:0] packet_offset;
  logic [COUNT_WIDTH-1:0]  payload_count;
  logic [COUNT_WIDTH-1:0]  byte_count;
  logic [15:0]             exposure_hold;
  logic [7:0]              sequence_hold;
  logic [7:0]              last_good_sequence;
  logic                    error_seen;

  logic [PROD_W-1:0]       prod;
  logic                    accept;
  logic                    take;
  logic                    err_now;
  logic                    ok;
  logic [COUNT_WIDTH-1:0]  byte_count_next;
  logic [COUNT_WIDTH-1:0]  payload_count_next;
  logic [OFFSET_WIDTH-1:0] packet_offset_next;
  logic [15:0]             exposure_next;
  logic [7:0]              sequence_next;

  assign prod = PROD_W'(img_width) * PROD_W'({1'b0, img_height} + 13'd1);

  assign rx.ready = !settle && !qstat.full;
  assign accept   = rx.valid && rx.ready;

  assign take = (packet_offset >= OFFSET_WIDTH'(HEADER_BYTES)) && (payload_count < flen);
  assign err_now = error_seen || rx.transfer_error;
  assign byte_count_next = (byte_count != COUNT_MAX) ? byte_count + 1'b1 : byte_count;
  assign payload_count_next = take ? payload_count + 1'b1 : payload_count;
  assign packet_offset_next = (packet_offset == OFFSET_WIDTH'(PACKET_BYTES - 1)) ?
                              '0 : packet_offset + 1'b1;

  always_comb begin
    exposure_next = exposure_hold;
    sequence_next = sequence_hold;
    if (take) begin
      if (payload_count == COUNT_WIDTH'(EXP_HI_POS)) begin
        exposure_next = {rx.data_byte, exposure_hold[7:0]};
      end else if (payload_count == COUNT_WIDTH'(EXP_LO_POS)) begin
        exposure_next = {exposure_hold[15:8], rx.data_byte};
      end else if (payload_count == COUNT_WIDTH'(SEQ_POS)) begin
        sequence_next = rx.data_byte;
      end
    end
  end

  assign ok = !err_now && (byte_count_next >= transfer_bytes) && (payload_count_next >= flen);

  assign push = accept && (take || rx.end_of_transfer);

  always_comb begin
    push_data          = '0;
    push_data.has_pix  = take;
    push_data.pixel    = rx.data_byte;
    push_data.has_sum  = rx.end_of_transfer;
    push_data.exposure = exposure_next;
    push_data.seq      = sequence_next;
    push_data.prev_seq = last_good_sequence;
    push_data.dark     = (exposure_next == 16'd0);
    push_data.ok       = ok;
  end

  always_ff @(posedge clk) begin
    flen <= (prod > PROD_W'(COUNT_MAX)) ? COUNT_MAX : prod[COUNT_WIDTH-1:0];
    if (rst) begin
      img_width          <= RST_IMG_WIDTH;
      img_height         <= RST_IMG_HEIGHT;
      transfer_bytes     <= RST_TRANSFER_BYTES;
      settle             <= 1'b1;
      packet_offset      <= '0;
      payload_count      <= '0;
      byte_count         <= '0;
      exposure_hold      <= '0;
      sequence_hold      <= '0;
      last_good_sequence <= '0;
      error_seen         <= 1'b0;
    end else begin
      // flen is registered; hold input off in the cycle after any config change
      settle <= cfg_we;
      if (cfg_we) begin
        case (cfg_index)
          REG_IMG_WIDTH:      img_width      <= cfg_data[WIDTH_BITS-1:0];
          REG_IMG_HEIGHT:     img_height     <= cfg_data[HEIGHT_BITS-1:0];
          REG_TRANSFER_BYTES: transfer_bytes <= cfg_data[COUNT_WIDTH-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (rx.end_of_transfer) begin
          packet_offset <= '0;
          payload_count <= '0;
          byte_count    <= '0;
          exposure_hold <= '0;
          sequence_hold <= '0;
          error_seen    <= 1'b0;
          if (ok) begin
            last_good_sequence <= sequence_next;
          end
        end else begin
          packet_offset <= packet_offset_next;
          payload_count <= payload_count_next;
          byte_count    <= byte_count_next;
          exposure_hold <= exposure_next;
          sequence_hold <= sequence_next;
          error_seen    <= err_now;
        end
      end
    end
  end

endmodule
`default_nettype wire

[rtl/ctd_queue.sv]
// ctd_queue: short FIFO of classified entries between front and back.
// Depends on ctd_pkg.
`default_nettype none
module ctd_queue
  import ctd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_data,
  input  wire logic   pop,
  output logic        head_valid,
  output entry_t      head,
  output q_stat_t     qstat
);

  entry_t              mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] count;
  logic                do_pop;

  assign head_valid  = (count != '0);
  assign head        = mem[rd_ptr];
  assign do_pop      = pop && head_valid;
  assign qstat.count = count;
  assign qstat.full  = (count == QUEUE_CW'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/ctd_back.sv]
// ctd_back: drains queue entries into result words, pixel before summary.
// Depends on ctd_pkg and ctd_out_if.
`default_nettype none
module ctd_back
  import ctd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   head_valid,
  input  wire entry_t head,
  output logic        pop,
  ctd_out_if.source   tx
);

  logic pix_done;
  logic load;
  logic emit_pix;

  assign load     = !tx.valid || tx.ready;
  assign emit_pix = head.has_pix && !pix_done;
  assign pop      = load && head_valid && !(emit_pix && head.has_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      tx.valid <= 1'b0;
      pix_done <= 1'b0;
    end else if (load) begin
      tx.valid <= head_valid;
      if (head_valid) begin
        pix_done <= emit_pix && head.has_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      if (emit_pix) begin
        tx.kind              <= KIND_PIXEL;
        tx.pixel             <= head.pixel;
        tx.exposure          <= '0;
        tx.sequence_res      <= '0;
        tx.previous_sequence <= '0;
        tx.dark_frame        <= 1'b0;
        tx.frame_ok          <= 1'b0;
        tx.last              <= 1'b0;
      end else begin
        tx.kind              <= KIND_SUMMARY;
        tx.pixel             <= '0;
        tx.exposure          <= head.exposure;
        tx.sequence_res      <= head.seq;
        tx.previous_sequence <= head.prev_seq;
        tx.dark_frame        <= head.dark;
        tx.frame_ok          <= head.ok;
        tx.last              <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/camera_transfer_deframer_top.sv]
// Camera transfer deframer: takes one transfer byte per cycle while ready, drops the
// 32-byte header of each 24576-byte packet, streams frame bytes as pixel words and
// emits a summary word (exposure, sequence, previous good sequence, dark flag,
// frame_ok) after the last byte of a transfer. Results leave through a 4-entry queue
// and an output register, one word per cycle unless the sink stalls, so a byte that
// ends a transfer and also carries a pixel yields two output words. Input ready drops
// while the queue is full and in the cycle after reset and each config write, while
// the registered frame length (width*(height+1), saturated to 24 bits) is recomputed.
// Pixels are sent before validity is known; drop the frame when frame_ok is 0.
// Depends on ctd_pkg, ctd_in_if, ctd_out_if, ctd_front, ctd_queue, ctd_back.
`default_nettype none
module camera_transfer_deframer_top
  import ctd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  ctd_in_if.sink                      rx,
  ctd_out_if.source                   tx
);

  logic    push;
  entry_t  push_data;
  logic    pop;
  logic    head_valid;
  entry_t  head;
  q_stat_t qstat;

  ctd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx        (rx),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  ctd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .qstat      (qstat)
  );

  ctd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .tx         (tx)
  );

  a_cfg_settle: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !rx.ready)
    else $error("input ready during frame length update");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    qstat.full |-> !push)
    else $error("push into full queue");

  a_pixel_clean: assert property (@(posedge clk) disable iff (rst)
    (tx.valid && tx.kind == KIND_PIXEL) |->
      (!tx.last && !tx.frame_ok && !tx.dark_frame && tx.exposure == 16'd0))
    else $error("pixel word carries summary fields");

  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    (tx.valid && tx.kind == KIND_SUMMARY) |-> (tx.last && tx.pixel == 8'd0))
    else $error("summary word malformed");

endmodule
`default_nettype wire

[bench/tb_camera_transfer_deframer_top.sv]
`timescale 1ns / 1ps
// tb_camera_transfer_deframer_top: self-checking bench for the camera transfer deframer.
// Sends transfer bytes with random gaps and stalls, predicts pixel and summary words.
// Depends on ctd_pkg, ctd_in_if, ctd_out_if and camera_transfer_deframer_top.
module tb_camera_transfer_deframer_top;
  import ctd_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_NONE = 2'd3;
  localparam int SETTLE_CYCLES = 20;
  localparam int QUIET_LIMIT   = 2000;
  localparam int MAX_REPORTS   = 100;
  localparam int RANDOM_ITEMS  = 1580;

  typedef struct {
    logic [7:0] data;
    logic       eot;
    logic       err;
  } byte_word_t;

  typedef struct {
    logic        kind;
    logic [7:0]  pixel;
    logic [15:0] exposure;
    logic [7:0]  seq;
    logic [7:0]  prev_seq;
    logic        dark;
    logic        ok;
    logic        last;
  } deframed_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  ctd_in_if  rx();
  ctd_out_if tx();

  camera_transfer_deframer_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx        (rx),
    .tx        (tx)
  );

  // register mirror
  logic [WIDTH_BITS-1:0]  fr_width  = RST_IMG_WIDTH;
  logic [HEIGHT_BITS-1:0] fr_height = RST_IMG_HEIGHT;
  logic [COUNT_WIDTH-1:0] fr_tbytes = RST_TRANSFER_BYTES;

  // deframer state mirror
  logic [OFFSET_WIDTH-1:0] pkt_off  = '0;
  logic [COUNT_WIDTH-1:0]  pay_cnt  = '0;
  logic [COUNT_WIDTH-1:0]  byte_cnt = '0;
  logic [15:0]             exp_hold = '0;
  logic [7:0]              seq_hold = '0;
  logic [7:0]              good_seq = '0;
  logic                    err_seen = 1'b0;

  byte_word_t outgoing_bytes[$];
  deframed_t  deframed_words[$];
  byte_word_t nxt;

  int unsigned fail_count = 0;
  int unsigned quiet = 0;
  int          hold;
  logic [2:0]  src_gap, snk_hold;
  logic        src_calm = 1'b0;
  logic        snk_calm = 1'b0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic void deframe_byte(byte_word_t w);
    longint                 prod;
    logic [COUNT_WIDTH-1:0] flen;
    deframed_t              d;
    logic                   ok;
    prod = longint'(fr_width) * (longint'(fr_height) + 1);
    flen = (prod > longint'(COUNT_MAX)) ? COUNT_MAX : prod[COUNT_WIDTH-1:0];
    if (w.err) err_seen = 1'b1;
    if (byte_cnt != COUNT_MAX) byte_cnt++;
    if (pkt_off >= HEADER_BYTES && pay_cnt < flen) begin
      if (pay_cnt == EXP_HI_POS) exp_hold[15:8] = w.data;
      else if (pay_cnt == EXP_LO_POS) exp_hold[7:0] = w.data;
      else if (pay_cnt == SEQ_POS) seq_hold = w.data;
      d = '{KIND_PIXEL, w.data, 16'h0, 8'h0, 8'h0, 1'b0, 1'b0, 1'b0};
      deframed_words.push_back(d);
      pay_cnt++;
    end
    pkt_off = (pkt_off == PACKET_BYTES - 1) ? '0 : pkt_off + 1'b1;
    if (w.eot) begin
      ok = !err_seen && byte_cnt >= fr_tbytes && pay_cnt >= flen;
      d = '{KIND_SUMMARY, 8'h0, exp_hold, seq_hold, good_seq, exp_hold == 16'h0, ok, 1'b1};
      deframed_words.push_back(d);
      if (ok) good_seq = seq_hold;
      pkt_off  = '0;
      pay_cnt  = '0;
      byte_cnt = '0;
      exp_hold = '0;
      seq_hold = '0;
      err_seen = 1'b0;
    end
  endfunction

  function automatic void field_check(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  function automatic void check_word();
    deframed_t want;
    if (deframed_words.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: word with none pending, kind %0h pixel %0h", $time, tx.kind, tx.pixel);
    end else begin
      want = deframed_words.pop_front();
      field_check("kind", want.kind, tx.kind);
      field_check("pixel", want.pixel, tx.pixel);
      field_check("exposure", want.exposure, tx.exposure);
      field_check("sequence_res", want.seq, tx.sequence_res);
      field_check("previous_sequence", want.prev_seq, tx.previous_sequence);
      field_check("dark_frame", want.dark, tx.dark_frame);
      field_check("frame_ok", want.ok, tx.frame_ok);
      field_check("last", want.last, tx.last);
    end
  endfunction

  // byte source
  always @(posedge clk) begin
    if (rst) begin
      rx.valid <= 1'b0;
      src_gap  <= '0;
    end else begin
      if (rx.valid && rx.ready)
        deframe_byte('{rx.data_byte, rx.end_of_transfer, rx.transfer_error});
      if (!rx.valid || rx.ready) begin
        if (src_gap != 0) begin
          src_gap  <= src_gap - 1'b1;
          rx.valid <= 1'b0;
        end else if (outgoing_bytes.size() != 0) begin
          nxt = outgoing_bytes.pop_front();
          rx.data_byte       <= nxt.data;
          rx.end_of_transfer <= nxt.eot;
          rx.transfer_error  <= nxt.err;
          rx.valid           <= 1'b1;
          src_gap            <= src_calm ? 3'd0 : 3'($urandom_range(0, 7));
        end else begin
          rx.valid <= 1'b0;
        end
      end
      if ($urandom_range(0, 63) == 0) src_calm <= ~src_calm;
    end
  end

  // result sink
  always @(posedge clk) begin
    if (rst) begin
      tx.ready <= 1'b0;
      snk_hold <= '0;
    end else begin
      if (tx.valid && tx.ready) begin
        check_word();
        hold = snk_calm ? 0 : $urandom_range(0, 7);
        snk_hold <= 3'(hold);
        tx.ready <= (hold == 0);
      end else if (snk_hold != 0) begin
        snk_hold <= snk_hold - 1'b1;
        tx.ready <= (snk_hold == 3'd1);
      end else begin
        tx.ready <= 1'b1;
      end
      if ($urandom_range(0, 63) == 0) snk_calm <= ~snk_calm;
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (rx.valid && rx.ready) || (tx.valid && tx.ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_IMG_WIDTH:      fr_width  = val[WIDTH_BITS-1:0];
      REG_IMG_HEIGHT:     fr_height = val[HEIGHT_BITS-1:0];
      REG_TRANSFER_BYTES: fr_tbytes = val[COUNT_WIDTH-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_byte(input logic [7:0] data, input logic eot, input logic err);
    byte_word_t w;
    w = '{data, eot, err};
    outgoing_bytes.push_back(w);
  endtask

  task automatic queue_transfer(input int len, input int err_at, input bit dark);
    logic [7:0] data;
    for (int i = 0; i < len; i++) begin
      data = 8'($urandom_range(0, 255));
      if (dark && (i == HEADER_BYTES + EXP_HI_POS || i == HEADER_BYTES + EXP_LO_POS))
        data = 8'h00;
      push_byte(data, i == len - 1, i == err_at);
    end
  endtask

  // hold off until every word is back and the block has gone quiet
  task automatic settle();
    while (outgoing_bytes.size() != 0 || rx.valid || deframed_words.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int fw, fh, span, tbytes, sent, goal, len, err_at, pick;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    rx.valid           = 1'b0;
    rx.data_byte       = '0;
    rx.end_of_transfer = 1'b0;
    rx.transfer_error  = 1'b0;
    tx.ready           = 1'b0;
    rst                = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings: header-only transfers, one errored, one single-word
    push_byte(8'h00, 1'b0, 1'b1);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'h5A, 1'b1, 1'b0);
    push_byte(8'hFF, 1'b1, 1'b0);
    settle();

    // empty frame counts as complete; unknown index must be ignored
    write_reg(REG_IMG_WIDTH, 24'd0);
    write_reg(REG_IMG_HEIGHT, 24'd0);
    write_reg(REG_TRANSFER_BYTES, 24'd1);
    write_reg(REG_NONE, 24'hFFFFFF);
    push_byte(8'h81, 1'b1, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h7E, 1'b1, 1'b1);
    settle();

    write_reg(REG_IMG_WIDTH, 24'd4096);
    write_reg(REG_IMG_HEIGHT, 24'd2048);
    write_reg(REG_TRANSFER_BYTES, 24'hFFFFFF);
    queue_transfer(40, -1, 1'b0);
    settle();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        fw = $urandom_range(60, 120);
        fh = 1;
      end else begin
        fw = $urandom_range(1, 24);
        fh = $urandom_range(1, 5);
      end
      span = HEADER_BYTES + fw * (fh + 1);
      tbytes = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, span))
                                           : span + int'($urandom_range(0, 3));
      write_reg(REG_IMG_WIDTH, 24'(fw));
      write_reg(REG_IMG_HEIGHT, 24'(fh));
      write_reg(REG_TRANSFER_BYTES, 24'(tbytes));
      goal = sent + 140;
      while (sent < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          len = $urandom_range(1, 45);
          err_at = ($urandom_range(0, 1) == 1) ? int'($urandom_range(0, len - 1)) : -1;
        end else begin
          len = ((tbytes > span) ? tbytes : span) + int'($urandom_range(0, 3));
          err_at = (pick < 50) ? int'($urandom_range(0, len - 1)) : -1;
        end
        queue_transfer(len, err_at, pick >= 85);
        sent += len;
      end
      settle();
    end

    if (fail_count == 0 && deframed_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
